>>> design/cdac_pkg.sv
// Shared types, constants and rounding helpers for the color dodge compositor.
package cdac_pkg;

	localparam int CH_W        = 16;
	localparam int NUM_CH      = 3;
	localparam int NUM_LANES   = NUM_CH + 1;
	localparam int RATIO_LANE  = NUM_CH;

	localparam int DIV_STEPS   = CH_W;
	localparam int NUM_W       = 2 * CH_W + 1;
	localparam int DEN_W       = CH_W + 1;
	localparam int REM_W       = DEN_W + CH_W + 1;

	localparam int ALPHA_STAGES = 6;
	localparam int SETUP_STAGE  = ALPHA_STAGES + 1;
	localparam int DIV_FIRST    = SETUP_STAGE + 1;
	localparam int DIV_LAST     = DIV_FIRST + DIV_STEPS - 1;
	localparam int MIX_STAGES   = 4;
	localparam int MIX_FIRST    = DIV_LAST + 1;
	localparam int PIPE_DEPTH   = DIV_LAST + MIX_STAGES;

	localparam logic [CH_W-1:0]   FRAC_ONE = {CH_W{1'b1}};
	localparam logic [2*CH_W-1:0] RND_HALF = 32'd32767;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t base_red;
		chan_t base_green;
		chan_t base_blue;
		chan_t base_alpha;
		chan_t layer_red;
		chan_t layer_green;
		chan_t layer_blue;
		chan_t layer_alpha;
		logic  last_pixel;
	} pix_t;

	typedef struct packed {
		chan_t out_red;
		chan_t out_green;
		chan_t out_blue;
		chan_t out_alpha;
		logic  out_last;
	} blend_t;

	// Everything that rides alongside the arithmetic from entry to exit.
	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] base_c;
		logic [NUM_CH-1:0][CH_W-1:0] layer_c;
		chan_t                       base_alpha;
		logic                        last;
		logic [NUM_CH-1:0]           sat;
		logic                        zero;
	} side_t;

	// First half of a rounded division by 65535: z already holds x + 32767.
	// The estimate is never above floor(z / 65535) and at most one below it.
	function automatic chan_t approx_div(input logic [2*CH_W-1:0] z);
		logic [2*CH_W:0] s;
		s = {1'b0, z} + {{(CH_W+1){1'b0}}, z[2*CH_W-1:CH_W]};
		return s[2*CH_W-1:CH_W];
	endfunction

	// Second half: one compare of the remainder fixes the estimate.
	function automatic chan_t fix_div(input logic [2*CH_W-1:0] z, input chan_t qa);
		logic [2*CH_W:0] r;
		r = {1'b0, z} - {1'b0, qa, {CH_W{1'b0}}} + {{(CH_W+1){1'b0}}, qa};
		return (r >= {{(CH_W+1){1'b0}}, FRAC_ONE}) ? qa + 16'd1 : qa;
	endfunction

endpackage

>>> design/cdac_alpha.sv
// Alpha path: composite alpha, new alpha, over six pipeline stages.
module cdac_alpha (
	input  logic                                clk,
	input  logic [cdac_pkg::ALPHA_STAGES-1:0]   en,
	input  cdac_pkg::chan_t                     base_alpha,
	input  cdac_pkg::chan_t                     layer_alpha,
	output cdac_pkg::chan_t                     comp,
	output cdac_pkg::chan_t                     nalf
);
	import cdac_pkg::*;

	logic [2*CH_W-1:0] prod_c;
	logic [2*CH_W-1:0] z2_c;
	logic [2*CH_W-1:0] prod4_c;
	logic [2*CH_W-1:0] z5_c;
	chan_t             inv_ba;

	logic [2*CH_W-1:0] prod_s1;
	chan_t             ba_s1;
	logic [2*CH_W-1:0] z_s2;
	chan_t             qa_s2;
	chan_t             ba_s2;
	chan_t             comp_s3;
	chan_t             ba_s3;
	logic [2*CH_W-1:0] prod_s4;
	chan_t             comp_s4;
	chan_t             ba_s4;
	logic [2*CH_W-1:0] z_s5;
	chan_t             qa_s5;
	chan_t             comp_s5;
	chan_t             ba_s5;
	chan_t             comp_s6;
	chan_t             nalf_s6;

	assign prod_c  = base_alpha * layer_alpha;
	assign z2_c    = prod_s1 + RND_HALF;
	assign inv_ba  = ~ba_s3;
	assign prod4_c = inv_ba * comp_s3;
	assign z5_c    = prod_s4 + RND_HALF;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= prod_c;
			ba_s1   <= base_alpha;
		end
		if (en[1]) begin
			z_s2  <= z2_c;
			qa_s2 <= approx_div(z2_c);
			ba_s2 <= ba_s1;
		end
		if (en[2]) begin
			comp_s3 <= fix_div(z_s2, qa_s2);
			ba_s3   <= ba_s2;
		end
		if (en[3]) begin
			prod_s4 <= prod4_c;
			comp_s4 <= comp_s3;
			ba_s4   <= ba_s3;
		end
		if (en[4]) begin
			z_s5    <= z5_c;
			qa_s5   <= approx_div(z5_c);
			comp_s5 <= comp_s4;
			ba_s5   <= ba_s4;
		end
		if (en[5]) begin
			// The rounded term never exceeds 1 - base, so the sum stays in range.
			nalf_s6 <= ba_s5 + fix_div(z_s5, qa_s5);
			comp_s6 <= comp_s5;
		end
	end

	assign comp = comp_s6;
	assign nalf = nalf_s6;

endmodule

>>> design/cdac_div_pipe.sv
// Restoring divider, one quotient bit per pipeline stage.
module cdac_div_pipe (
	input  logic                             clk,
	input  logic [cdac_pkg::DIV_STEPS-1:0]   en,
	input  logic [cdac_pkg::NUM_W-1:0]       num,
	input  logic [cdac_pkg::DEN_W-1:0]       den,
	output cdac_pkg::chan_t                  quo
);
	import cdac_pkg::*;

	// The numerator must be below den * 2^16; the partial remainder is kept
	// doubled so that every stage compares against the same shifted divisor.
	logic [REM_W-1:0] rem_in [DIV_STEPS];
	logic [DEN_W-1:0] den_in [DIV_STEPS];
	chan_t            quo_in [DIV_STEPS];

	logic [REM_W-1:0] rem_s [1:DIV_STEPS-1];
	logic [DEN_W-1:0] den_s [1:DIV_STEPS-1];
	chan_t            quo_s [1:DIV_STEPS];

	assign rem_in[0] = {num, 1'b0};
	assign den_in[0] = den;
	assign quo_in[0] = '0;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [REM_W-1:0] dsh;
		logic             ge;
		logic [REM_W-1:0] diff;

		assign dsh  = {1'b0, den_in[j], {CH_W{1'b0}}};
		assign ge   = rem_in[j] >= dsh;
		assign diff = ge ? rem_in[j] - dsh : rem_in[j];

		always_ff @(posedge clk) begin
			if (en[j]) begin
				quo_s[j+1] <= {quo_in[j][CH_W-2:0], ge};
			end
		end

		if (j < DIV_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j+1] <= {diff[REM_W-2:0], 1'b0};
					den_s[j+1] <= den_in[j];
				end
			end
			assign rem_in[j+1] = rem_s[j+1];
			assign den_in[j+1] = den_s[j+1];
			assign quo_in[j+1] = quo_s[j+1];
		end
	end

	assign quo = quo_s[DIV_STEPS];

endmodule

>>> design/cdac_mix.sv
// Color mix: dodge * ratio + base * (1 - ratio), rounded, over four stages.
module cdac_mix (
	input  logic                                         clk,
	input  logic [cdac_pkg::MIX_STAGES-1:0]              en,
	input  logic [cdac_pkg::NUM_CH-1:0][cdac_pkg::CH_W-1:0] dodge_q,
	input  logic [cdac_pkg::NUM_CH-1:0]                  sat,
	input  cdac_pkg::chan_t                              ratio_q,
	input  logic                                         zero,
	input  logic [cdac_pkg::NUM_CH-1:0][cdac_pkg::CH_W-1:0] base_c,
	output logic [cdac_pkg::NUM_CH-1:0][cdac_pkg::CH_W-1:0] color
);
	import cdac_pkg::*;

	chan_t ratio;
	chan_t inv_ratio;

	logic [2*CH_W-1:0] p1_s1 [NUM_CH];
	logic [2*CH_W-1:0] p2_s1 [NUM_CH];
	logic [2*CH_W-1:0] z_s2  [NUM_CH];
	logic [2*CH_W-1:0] z_s3  [NUM_CH];
	chan_t             qa_s3 [NUM_CH];
	chan_t             out_s4 [NUM_CH];

	// With no coverage at all the ratio is zero and the base color passes.
	assign ratio     = zero ? '0 : ratio_q;
	assign inv_ratio = ~ratio;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		chan_t             dodge;
		logic [2*CH_W-1:0] p1_c;
		logic [2*CH_W-1:0] p2_c;

		assign dodge = sat[c] ? FRAC_ONE : dodge_q[c];
		assign p1_c  = dodge * ratio;
		assign p2_c  = base_c[c] * inv_ratio;

		always_ff @(posedge clk) begin
			if (en[0]) begin
				p1_s1[c] <= p1_c;
				p2_s1[c] <= p2_c;
			end
			if (en[1]) begin
				z_s2[c] <= p1_s1[c] + p2_s1[c] + RND_HALF;
			end
			if (en[2]) begin
				z_s3[c]  <= z_s2[c];
				qa_s3[c] <= approx_div(z_s2[c]);
			end
			if (en[3]) begin
				out_s4[c] <= fix_div(z_s3[c], qa_s3[c]);
			end
		end

		assign color[c] = out_s4[c];
	end

endmodule

>>> design/color_dodge_alpha_compositor.sv
// Top level of the color dodge compositor: pipeline control, divider setup, lanes.
//
//   channel   valid         stall         payload         direction
//   pixel     pix_valid     pix_stall     pix   (pix_t)   in
//   result    blend_valid   blend_stall   blend (blend_t) out
//
// One pixel enters per clock while the result side does not stall; each result
// passes six alpha stages, one divider setup stage, sixteen one-bit divider
// stages and four mix stages. Empty stages close up while the result side
// stalls, so pixels are taken until every stage holds one. Reset clears only
// the stage valid bits; the pipeline is usable in the first cycle after reset.
module color_dodge_alpha_compositor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  cdac_pkg::pix_t   pix,
	output logic             blend_valid,
	input  logic             blend_stall,
	output cdac_pkg::blend_t blend
);
	import cdac_pkg::*;

	logic [PIPE_DEPTH:1]   v_q;
	logic [PIPE_DEPTH:1]   ready;
	side_t                 side_s [1:PIPE_DEPTH];

	side_t                 entry_side;
	side_t                 setup_side;
	chan_t                 comp;
	chan_t                 nalf;

	logic [NUM_W-1:0]      setup_num [NUM_LANES];
	logic [DEN_W-1:0]      setup_den [NUM_LANES];
	logic [NUM_W-1:0]      num_s7    [NUM_LANES];
	logic [DEN_W-1:0]      den_s7    [NUM_LANES];
	chan_t                 quo       [NUM_LANES];

	logic [NUM_CH-1:0][CH_W-1:0] dodge_q;
	logic [NUM_CH-1:0][CH_W-1:0] color;

	// A stage may load when the result side is free or it or some later stage is empty.
	for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_ready
		assign ready[k] = !blend_stall || !(&v_q[PIPE_DEPTH:k]);
	end

	assign pix_stall = !ready[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ready[1]) begin
				v_q[1] <= pix_valid;
			end
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (ready[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	always_comb begin
		entry_side            = '0;
		entry_side.base_c     = {pix.base_blue, pix.base_green, pix.base_red};
		entry_side.layer_c    = {pix.layer_blue, pix.layer_green, pix.layer_red};
		entry_side.base_alpha = pix.base_alpha;
		entry_side.last       = pix.last_pixel;
	end

	cdac_alpha u_alpha (
		.clk         (clk),
		.en          (ready[ALPHA_STAGES:1]),
		.base_alpha  (pix.base_alpha),
		.layer_alpha (pix.layer_alpha),
		.comp        (comp),
		.nalf        (nalf)
	);

	// Divider setup: numerator 2 * a * 65535 + b and denominator 2 * b give
	// round-to-nearest of a * 65535 / b after a plain floor division.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_setup
		chan_t gap;
		assign gap = ~side_s[ALPHA_STAGES].layer_c[c];
		assign setup_num[c] = {side_s[ALPHA_STAGES].base_c[c], {(CH_W+1){1'b0}}}
			- {{CH_W{1'b0}}, side_s[ALPHA_STAGES].base_c[c], 1'b0}
			+ {{(CH_W+1){1'b0}}, gap};
		assign setup_den[c] = {gap, 1'b0};
	end

	assign setup_num[RATIO_LANE] = {comp, {(CH_W+1){1'b0}}}
		- {{CH_W{1'b0}}, comp, 1'b0}
		+ {{(CH_W+1){1'b0}}, nalf};
	assign setup_den[RATIO_LANE] = {nalf, 1'b0};

	always_comb begin
		setup_side = side_s[ALPHA_STAGES];
		// A full layer channel has a zero gap and always lands here.
		for (int c = 0; c < NUM_CH; c++) begin
			setup_side.sat[c] = setup_num[c] >= {setup_den[c], {CH_W{1'b0}}};
		end
		setup_side.zero = (nalf == '0);
	end

	for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_side
		if (k == 1) begin : g_entry
			always_ff @(posedge clk) begin
				if (ready[k]) begin
					side_s[k] <= entry_side;
				end
			end
		end else if (k == SETUP_STAGE) begin : g_flags
			always_ff @(posedge clk) begin
				if (ready[k]) begin
					side_s[k] <= setup_side;
				end
			end
		end else begin : g_copy
			always_ff @(posedge clk) begin
				if (ready[k]) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready[SETUP_STAGE]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				num_s7[l] <= setup_num[l];
				den_s7[l] <= setup_den[l];
			end
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		cdac_div_pipe u_div (
			.clk (clk),
			.en  (ready[DIV_LAST:DIV_FIRST]),
			.num (num_s7[l]),
			.den (den_s7[l]),
			.quo (quo[l])
		);
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_dodge
		assign dodge_q[c] = quo[c];
	end

	cdac_mix u_mix (
		.clk     (clk),
		.en      (ready[PIPE_DEPTH:MIX_FIRST]),
		.dodge_q (dodge_q),
		.sat     (side_s[DIV_LAST].sat),
		.ratio_q (quo[RATIO_LANE]),
		.zero    (side_s[DIV_LAST].zero),
		.base_c  (side_s[DIV_LAST].base_c),
		.color   (color)
	);

	assign blend_valid     = v_q[PIPE_DEPTH];
	assign blend.out_red   = color[0];
	assign blend.out_green = color[1];
	assign blend.out_blue  = color[2];
	assign blend.out_alpha = side_s[PIPE_DEPTH].base_alpha;
	assign blend.out_last  = side_s[PIPE_DEPTH].last;

	// A free result side must never hold back the pixel side.
	a_free_output_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!blend_stall |-> !pix_stall)
		else $error("pixel side stalled while result side is free");

	// An empty pipeline always takes a pixel.
	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q == '0) |-> !pix_stall)
		else $error("pixel side stalled with an empty pipeline");

	// Composite alpha never exceeds the new alpha, so the ratio fits sixteen bits.
	a_ratio_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[SETUP_STAGE] && !side_s[SETUP_STAGE].zero) |->
		(num_s7[RATIO_LANE] < {den_s7[RATIO_LANE], {CH_W{1'b0}}}))
		else $error("ratio quotient out of range at divider entry");

	// A stalled result stays on the port unchanged until its transfer.
	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(blend_valid && blend_stall) |=> (blend_valid && $stable(blend)))
		else $error("stalled result changed or dropped");

endmodule
